>>> hdl/rvcsr_pkg.sv
// Shared types, constants and address decode for the RISC-V CSR file.
// No dependencies; imported by rvcsr_regs and the top level.
`default_nettype none
package rvcsr_pkg;

    localparam int NUM_CSRS = 29;
    localparam int SLOT_W   = 5;
    localparam int XLEN     = 64;
    localparam int ILEN     = 32;

    // Operation codes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_RAISE = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // Storage slots, in store order
    localparam logic [SLOT_W-1:0] SL_SEPC       = 5'd0;
    localparam logic [SLOT_W-1:0] SL_STVEC      = 5'd1;
    localparam logic [SLOT_W-1:0] SL_SCAUSE     = 5'd2;
    localparam logic [SLOT_W-1:0] SL_STVAL      = 5'd3;
    localparam logic [SLOT_W-1:0] SL_SSCRATCH   = 5'd4;
    localparam logic [SLOT_W-1:0] SL_SSTATUS    = 5'd5;
    localparam logic [SLOT_W-1:0] SL_SATP       = 5'd6;
    localparam logic [SLOT_W-1:0] SL_SIE        = 5'd7;
    localparam logic [SLOT_W-1:0] SL_SIP        = 5'd8;
    localparam logic [SLOT_W-1:0] SL_MTVEC      = 5'd9;
    localparam logic [SLOT_W-1:0] SL_MEPC       = 5'd10;
    localparam logic [SLOT_W-1:0] SL_MCAUSE     = 5'd11;
    localparam logic [SLOT_W-1:0] SL_MIE        = 5'd12;
    localparam logic [SLOT_W-1:0] SL_MIP        = 5'd13;
    localparam logic [SLOT_W-1:0] SL_MTVAL      = 5'd14;
    localparam logic [SLOT_W-1:0] SL_MSCRATCH   = 5'd15;
    localparam logic [SLOT_W-1:0] SL_MSTATUS    = 5'd16;
    localparam logic [SLOT_W-1:0] SL_MHARTID    = 5'd17;
    localparam logic [SLOT_W-1:0] SL_MEDELEG    = 5'd18;
    localparam logic [SLOT_W-1:0] SL_MIDELEG    = 5'd19;
    localparam logic [SLOT_W-1:0] SL_PMPADDR0   = 5'd20;
    localparam logic [SLOT_W-1:0] SL_PMPADDR1   = 5'd21;
    localparam logic [SLOT_W-1:0] SL_PMPADDR2   = 5'd22;
    localparam logic [SLOT_W-1:0] SL_PMPADDR3   = 5'd23;
    localparam logic [SLOT_W-1:0] SL_PMPCFG0    = 5'd24;
    localparam logic [SLOT_W-1:0] SL_USCRATCH   = 5'd25;
    localparam logic [SLOT_W-1:0] SL_MISA       = 5'd26;
    localparam logic [SLOT_W-1:0] SL_SCOUNTEREN = 5'd27;
    localparam logic [SLOT_W-1:0] SL_MCOUNTEREN = 5'd28;

    // Writable masks
    localparam logic [XLEN-1:0] SMASK        = 64'h0000_0000_000D_E722;
    localparam logic [XLEN-1:0] MMASK        = 64'h0000_0000_007E_7FAA;
    localparam logic [XLEN-1:0] SD_MASK      = 64'h8000_0000_0000_0000;
    localparam logic [XLEN-1:0] SUP_INTS     = 64'h0000_0000_0000_0222;
    localparam logic [XLEN-1:0] DELEG_MASK   = 64'h0000_0000_0000_B309;
    localparam logic [XLEN-1:0] SATP_MASK    = 64'hF000_0FFF_FFFF_FFFF;
    localparam logic [XLEN-1:0] PMPADDR_MASK = 64'h003F_FFFF_FFFF_FFFF;
    localparam logic [XLEN-1:0] CNTEN_MASK   = 64'h0000_0000_FFFF_FFFF;

    // Address bits 11:10 all ones marks a read-only CSR
    localparam logic [1:0] RO_CODE = 2'b11;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } csr_slot_t;

    // One state-changing request from the pipeline to the register bank
    typedef struct packed {
        logic              wr_en;
        logic              set_en;
        logic              clr_en;
        logic [SLOT_W-1:0] slot;
        logic [XLEN-1:0]   wdata;
        logic [4:0]        irq;
    } csr_cmd_t;

    function automatic logic [XLEN-1:0] merge(input logic [XLEN-1:0] old_val,
                                              input logic [XLEN-1:0] mask,
                                              input logic [XLEN-1:0] new_val);
        merge = (old_val & ~mask) | (new_val & mask);
    endfunction

    // Map a CSR address to its storage slot
    function automatic csr_slot_t slot_lookup(input logic [11:0] addr);
        csr_slot_t r;
        r.hit  = 1'b1;
        r.slot = SL_SEPC;
        case (addr)
            12'h141: r.slot = SL_SEPC;
            12'h105: r.slot = SL_STVEC;
            12'h142: r.slot = SL_SCAUSE;
            12'h143: r.slot = SL_STVAL;
            12'h140: r.slot = SL_SSCRATCH;
            12'h100: r.slot = SL_SSTATUS;
            12'h180: r.slot = SL_SATP;
            12'h104: r.slot = SL_SIE;
            12'h144: r.slot = SL_SIP;
            12'h305: r.slot = SL_MTVEC;
            12'h341: r.slot = SL_MEPC;
            12'h342: r.slot = SL_MCAUSE;
            12'h304: r.slot = SL_MIE;
            12'h344: r.slot = SL_MIP;
            12'h343: r.slot = SL_MTVAL;
            12'h340: r.slot = SL_MSCRATCH;
            12'h300: r.slot = SL_MSTATUS;
            12'hF14: r.slot = SL_MHARTID;
            12'h302: r.slot = SL_MEDELEG;
            12'h303: r.slot = SL_MIDELEG;
            12'h3B0: r.slot = SL_PMPADDR0;
            12'h3B1: r.slot = SL_PMPADDR1;
            12'h3B2: r.slot = SL_PMPADDR2;
            12'h3B3: r.slot = SL_PMPADDR3;
            12'h3A0: r.slot = SL_PMPCFG0;
            12'h040: r.slot = SL_USCRATCH;
            12'h301: r.slot = SL_MISA;
            12'h106: r.slot = SL_SCOUNTEREN;
            12'h306: r.slot = SL_MCOUNTEREN;
            default: r.hit  = 1'b0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hdl/rvcsr_regs.sv
// CSR register bank: storage, read mux and masked update with shadowing.
// Depends on rvcsr_pkg.
`default_nettype none
module rvcsr_regs
    import rvcsr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire csr_cmd_t          cmd,
    input  wire logic [SLOT_W-1:0] rd_slot,
    output logic      [XLEN-1:0]   rd_data
);

    logic [XLEN-1:0] csr_reg  [NUM_CSRS];
    logic [XLEN-1:0] csr_next [NUM_CSRS];

    // Read port; slots past the end read as zero
    assign rd_data = (rd_slot < SLOT_W'(NUM_CSRS)) ? csr_reg[rd_slot] : '0;

    // Compute the next bank contents for one request
    always_comb begin
        logic [XLEN-1:0] v;
        logic [XLEN-1:0] ss;
        logic [XLEN-1:0] ms;
        logic [XLEN-1:0] new_sie;
        logic            dirty;
        v       = cmd.wdata;
        ss      = '0;
        ms      = '0;
        new_sie = '0;
        dirty   = 1'b0;
        for (int i = 0; i < NUM_CSRS; i++) begin
            csr_next[i] = csr_reg[i];
        end
        if (cmd.set_en) begin
            csr_next[SL_MIP] = csr_reg[SL_MIP] | (XLEN'(1) << cmd.irq);
        end else if (cmd.clr_en) begin
            csr_next[SL_MIP] = csr_reg[SL_MIP] & ~(XLEN'(1) << cmd.irq);
        end else if (cmd.wr_en) begin
            case (cmd.slot)
                SL_MEDELEG: begin
                    csr_next[SL_MEDELEG] = merge(csr_reg[SL_MEDELEG], DELEG_MASK, v);
                end
                SL_MIDELEG: begin
                    csr_next[SL_MIDELEG] = merge(csr_reg[SL_MIDELEG], SUP_INTS, v);
                end
                SL_SIE: begin
                    // sie writes only delegated bits, then mirrors them into mie
                    new_sie = merge(csr_reg[SL_SIE], csr_reg[SL_MIDELEG], v);
                    csr_next[SL_SIE] = new_sie;
                    csr_next[SL_MIE] = merge(csr_reg[SL_MIE], csr_reg[SL_MIDELEG],
                                             new_sie);
                end
                SL_SSTATUS: begin
                    ss    = merge(csr_reg[SL_SSTATUS], SMASK, v);
                    ms    = merge(csr_reg[SL_MSTATUS], SMASK, v);
                    dirty = (ms[14:13] == 2'b11) || (ms[16:15] == 2'b11);
                    ms[XLEN-1] = dirty;
                    ss[XLEN-1] = dirty;
                    csr_next[SL_SSTATUS] = ss;
                    csr_next[SL_MSTATUS] = ms;
                end
                SL_MSTATUS: begin
                    ms    = merge(csr_reg[SL_MSTATUS], MMASK, v);
                    dirty = (ms[14:13] == 2'b11) || (ms[16:15] == 2'b11);
                    ms[XLEN-1] = dirty;
                    csr_next[SL_MSTATUS] = ms;
                    csr_next[SL_SSTATUS] = merge(csr_reg[SL_SSTATUS],
                                                 SMASK | SD_MASK, ms);
                end
                SL_SIP, SL_MIP: begin
                    csr_next[SL_SIP] = merge(csr_reg[SL_SIP], SUP_INTS, v);
                    csr_next[SL_MIP] = merge(csr_reg[SL_MIP], SUP_INTS, v);
                end
                SL_SATP: begin
                    csr_next[SL_SATP] = merge(csr_reg[SL_SATP], SATP_MASK, v);
                end
                SL_PMPADDR0, SL_PMPADDR1, SL_PMPADDR2, SL_PMPADDR3: begin
                    csr_next[cmd.slot] = merge(csr_reg[cmd.slot], PMPADDR_MASK, v);
                end
                SL_SCOUNTEREN, SL_MCOUNTEREN: begin
                    csr_next[cmd.slot] = v & CNTEN_MASK;
                end
                default: begin
                    if (cmd.slot < SLOT_W'(NUM_CSRS)) begin
                        csr_next[cmd.slot] = v;
                    end
                end
            endcase
        end
    end

    // Hold the bank; clear all CSRs on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CSRS; i++) begin
                csr_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < NUM_CSRS; i++) begin
                csr_reg[i] <= csr_next[i];
            end
        end
    end

endmodule
`default_nettype wire

>>> hdl/riscv_csr_file_with_access_check_core.sv
// Top level of the RISC-V CSR file with privilege and access checking.
// Depends on rvcsr_pkg and rvcsr_regs.
//
//  channel | direction | fields
//  s_*     | in        | opcode, csr_address, write_data, current_privilege,
//          |           | instruction_word, irq_number
//  m_*     | out       | read_data, trap, trap_value
//
// An item waits in the input register and is then executed: the check,
// the read and the CSR update all happen on the edge that moves it into
// the result register, which also raises m_valid; one item per cycle is
// sustained while m_ready is high.
// Synchronous active-low reset clears both valid flags and all CSRs.
// A stalled m_ready holds the result register, and the input register fills
// behind it; s_ready drops only when both are full.
`default_nettype none
module riscv_csr_file_with_access_check_core
    import rvcsr_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [1:0]      s_opcode,
    input  wire logic [11:0]     s_csr_address,
    input  wire logic [XLEN-1:0] s_write_data,
    input  wire logic [1:0]      s_current_privilege,
    input  wire logic [ILEN-1:0] s_instruction_word,
    input  wire logic [4:0]      s_irq_number,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic      [XLEN-1:0] m_read_data,
    output logic                 m_trap,
    output logic      [ILEN-1:0] m_trap_value
);

    logic            in_vld_reg;
    logic [1:0]      op_reg;
    logic [11:0]     addr_reg;
    logic [XLEN-1:0] wdata_reg;
    logic [1:0]      priv_reg;
    logic [ILEN-1:0] instr_reg;
    logic [4:0]      irq_reg;

    logic            out_vld_reg;
    logic [XLEN-1:0] rdata_reg;
    logic            trap_reg;
    logic [ILEN-1:0] tval_reg;

    logic            advance;
    logic            is_access;
    logic            bad;
    csr_slot_t       dec;
    csr_cmd_t        cmd;
    logic [XLEN-1:0] bank_rdata;

    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    // Decode and check the held item
    assign dec       = slot_lookup(addr_reg);
    assign is_access = (op_reg == OP_READ) || (op_reg == OP_WRITE);
    assign bad       = (addr_reg[9:8] > priv_reg) || !dec.hit
                    || ((op_reg == OP_WRITE) && (addr_reg[11:10] == RO_CODE));

    assign cmd.wr_en  = advance && (op_reg == OP_WRITE) && !bad;
    assign cmd.set_en = advance && (op_reg == OP_RAISE);
    assign cmd.clr_en = advance && (op_reg == OP_CLEAR);
    assign cmd.slot   = dec.slot;
    assign cmd.wdata  = wdata_reg;
    assign cmd.irq    = irq_reg;

    rvcsr_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .rd_slot (dec.slot),
        .rd_data (bank_rdata)
    );

    // Input register: load on acceptance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            op_reg    <= s_opcode;
            addr_reg  <= s_csr_address;
            wdata_reg <= s_write_data;
            priv_reg  <= s_current_privilege;
            instr_reg <= s_instruction_word;
            irq_reg   <= s_irq_number;
        end
    end

    // Result register: capture the executed item, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
        if (advance) begin
            rdata_reg <= ((op_reg == OP_READ) && !bad) ? bank_rdata : '0;
            trap_reg  <= is_access && bad;
            tval_reg  <= (is_access && bad) ? instr_reg : '0;
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_read_data  = rdata_reg;
    assign m_trap       = trap_reg;
    assign m_trap_value = tval_reg;

endmodule
`default_nettype wire
